/* sv/frame_ring_queue_defines.svh */
// Assertion macros for the frame ring queue.
// Used by the top level; no other dependencies.
`ifndef FRAME_RING_QUEUE_DEFINES_SVH
`define FRAME_RING_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FRQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame ring queue: check failed");
// next-cycle implication
`define FRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame ring queue: check failed");
`else
`define FRQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/frq_pkg.sv */
// Shared types and constants of the frame ring queue.
// No dependencies; imported by the controller, datapath and top level.
package frq_pkg;

	localparam int FRAMES_DEF      = 8;
	localparam int FRAME_BYTES_DEF = 64;

	// fixed field widths
	localparam int OP_W   = 2;
	localparam int LEN_W  = 7;
	localparam int TS_W   = 64;
	localparam int TAG_W  = 32;
	localparam int BYTE_W = 8;
	localparam int STAT_W = 2;

	// opcodes
	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_POP  = 2'd1;
	localparam logic [OP_W-1:0] OP_DROP = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVERSIZE = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

	// what the output register is loaded with
	typedef enum logic [2:0] {
		KIND_PUSH,
		KIND_EMPTY,
		KIND_DROP,
		KIND_BYTE,
		KIND_META
	} kind_t;

	// controller to datapath
	typedef struct packed {
		logic  push;
		logic  pop_start;
		logic  pop_next;
		logic  pop_done;
		logic  drop;
		logic  out_load;
		kind_t kind;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic oready;
		logic n_zero;
		logic last_byte;
	} stat_t;

endpackage

/* sv/frq_ctrl.sv */
// Controller of the frame ring queue: idle / pop-stream state machine.
// Depends on frq_pkg.
module frq_ctrl import frq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] opcode,
	input  logic            end_of_frame,
	input  stat_t           stat,
	output logic            in_stall,
	output cmd_t            cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_POP  = 1'b1;

	logic state_q, state_d;
	logic acc;

	// input side is open only in idle with room in the output register
	assign in_stall = (state_q != S_IDLE) || !stat.oready;
	assign acc      = in_valid && !in_stall;

	// command decode
	always_comb begin
		cmd     = '0;
		cmd.kind = KIND_PUSH;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (opcode)
						OP_PUSH: begin
							cmd.push     = 1'b1;
							cmd.out_load = end_of_frame;
							cmd.kind     = KIND_PUSH;
						end
						OP_POP: begin
							if (stat.empty) begin
								cmd.out_load = 1'b1;
								cmd.kind     = KIND_EMPTY;
							end else begin
								cmd.pop_start = 1'b1;
								state_d       = S_POP;
							end
						end
						OP_DROP: begin
							cmd.out_load = 1'b1;
							cmd.kind     = stat.empty ? KIND_EMPTY : KIND_DROP;
							cmd.drop     = !stat.empty;
						end
						default: begin
						end
					endcase
				end
			end
			S_POP: begin
				if (stat.oready) begin
					cmd.out_load = 1'b1;
					if (stat.n_zero) begin
						cmd.kind     = KIND_META;
						cmd.pop_done = 1'b1;
						state_d      = S_IDLE;
					end else begin
						cmd.kind = KIND_BYTE;
						if (stat.last_byte) begin
							cmd.pop_done = 1'b1;
							state_d      = S_IDLE;
						end else begin
							cmd.pop_next = 1'b1;
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* sv/frq_dp.sv */
// Datapath of the frame ring queue: ring pointers, payload and metadata
// memories, read-out counter and output register. Depends on frq_pkg.
module frq_dp import frq_pkg::*; #(
	parameter int FRAMES      = FRAMES_DEF,
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output stat_t                    stat,
	input  logic [BYTE_W-1:0]        data_byte,
	input  logic                     end_of_frame,
	input  logic signed [TS_W-1:0]   timestamp,
	input  logic [TAG_W-1:0]         tag_a,
	input  logic [TAG_W-1:0]         tag_b,
	input  logic [LEN_W-1:0]         read_limit,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic [STAT_W-1:0]        status,
	output logic                     byte_valid,
	output logic [BYTE_W-1:0]        out_byte,
	output logic                     last,
	output logic [LEN_W-1:0]         copied_length,
	output logic signed [TS_W-1:0]   out_timestamp,
	output logic [TAG_W-1:0]         out_tag_a,
	output logic [TAG_W-1:0]         out_tag_b
);

	localparam int DEPTH  = FRAMES * FRAME_BYTES;
	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W  = $clog2(FRAMES + 1);
	localparam int FILL_W = $clog2(FRAME_BYTES + 1);
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// storage
	logic [BYTE_W-1:0] pay_mem [DEPTH];
	logic [LEN_W-1:0]  len_mem [FRAMES];
	logic [TS_W-1:0]   ts_mem  [FRAMES];
	logic [TAG_W-1:0]  ta_mem  [FRAMES];
	logic [TAG_W-1:0]  tb_mem  [FRAMES];

	// ring control
	logic [IDX_W-1:0]  rear_q, front_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [FILL_W-1:0] fill_q;
	logic [STAT_W-1:0] rej_q;

	// read side
	logic [LEN_W-1:0]  lim_q, k_q;
	logic [BYTE_W-1:0] rd_byte_q;
	logic [LEN_W-1:0]  rd_len_q;
	logic [TS_W-1:0]   rd_ts_q;
	logic [TAG_W-1:0]  rd_ta_q, rd_tb_q;

	logic              out_valid_q;
	logic              full, store_ok, commit, adv_front;
	logic [STAT_W-1:0] rej_new;
	logic [LEN_W-1:0]  n_len, k_inc;
	logic [ADDR_W-1:0] wr_addr, rd_addr;

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
		next_slot = (i == IDX_W'(FRAMES - 1)) ? '0 : i + 1'b1;
	endfunction

	// push decision: first rejection sticks
	assign full     = (cnt_q == CNT_W'(FRAMES));
	always_comb begin
		if (rej_q != ST_OK)                      rej_new = rej_q;
		else if (full)                           rej_new = ST_FULL;
		else if (fill_q >= FILL_W'(FRAME_BYTES)) rej_new = ST_OVERSIZE;
		else                                     rej_new = ST_OK;
	end
	assign store_ok  = cmd.push && (rej_new == ST_OK);
	assign commit    = cmd.push && end_of_frame && (rej_new == ST_OK);
	assign adv_front = cmd.pop_done || cmd.drop;

	assign wr_addr = ADDR_W'(rear_q) * ADDR_W'(FRAME_BYTES) + ADDR_W'(fill_q);
	assign k_inc   = k_q + 1'b1;
	assign rd_addr = ADDR_W'(front_q) * ADDR_W'(FRAME_BYTES)
		+ (cmd.pop_next ? ADDR_W'(k_inc) : ADDR_W'(0));

	// payload memory
	always_ff @(posedge clk) begin
		if (store_ok) begin
			pay_mem[wr_addr] <= data_byte;
		end
		if (cmd.pop_start || cmd.pop_next) begin
			rd_byte_q <= pay_mem[rd_addr];
		end
	end

	// metadata memories
	always_ff @(posedge clk) begin
		if (commit) begin
			len_mem[rear_q] <= LEN_W'(fill_q) + 1'b1;
			ts_mem[rear_q]  <= timestamp;
			ta_mem[rear_q]  <= tag_a;
			tb_mem[rear_q]  <= tag_b;
		end
		if (cmd.pop_start) begin
			rd_len_q <= len_mem[front_q];
			rd_ts_q  <= ts_mem[front_q];
			rd_ta_q  <= ta_mem[front_q];
			rd_tb_q  <= tb_mem[front_q];
			lim_q    <= read_limit;
		end
	end

	// read-out byte counter
	always_ff @(posedge clk) begin
		if (cmd.pop_start) begin
			k_q <= '0;
		end else if (cmd.pop_next) begin
			k_q <= k_inc;
		end
	end

	// ring pointers, frame count, write fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rear_q  <= '0;
			front_q <= '0;
			cnt_q   <= '0;
			fill_q  <= '0;
			rej_q   <= ST_OK;
		end else begin
			if (cmd.push) begin
				if (end_of_frame) begin
					fill_q <= '0;
					rej_q  <= ST_OK;
				end else begin
					rej_q <= rej_new;
					if (store_ok) begin
						fill_q <= fill_q + 1'b1;
					end
				end
			end
			if (commit) begin
				rear_q <= next_slot(rear_q);
				cnt_q  <= cnt_q + 1'b1;
			end else if (adv_front) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (adv_front) begin
				front_q <= next_slot(front_q);
			end
		end
	end

	// status to controller
	assign n_len          = (lim_q < rd_len_q) ? lim_q : rd_len_q;
	assign stat.empty     = (cnt_q == '0);
	assign stat.oready    = !out_valid_q || !out_stall;
	assign stat.n_zero    = (n_len == '0);
	assign stat.last_byte = (k_inc == n_len);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status        <= ST_OK;
			byte_valid    <= 1'b0;
			out_byte      <= '0;
			last          <= 1'b1;
			copied_length <= '0;
			out_timestamp <= '0;
			out_tag_a     <= '0;
			out_tag_b     <= '0;
			case (cmd.kind)
				KIND_PUSH:  status <= rej_new;
				KIND_EMPTY: status <= ST_EMPTY;
				KIND_DROP:  status <= ST_OK;
				KIND_BYTE: begin
					byte_valid    <= 1'b1;
					out_byte      <= rd_byte_q;
					last          <= stat.last_byte;
					copied_length <= n_len;
					out_timestamp <= rd_ts_q;
					out_tag_a     <= rd_ta_q;
					out_tag_b     <= rd_tb_q;
				end
				KIND_META: begin
					out_timestamp <= rd_ts_q;
					out_tag_a     <= rd_ta_q;
					out_tag_b     <= rd_tb_q;
				end
				default: status <= ST_OK;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* sv/frame_ring_queue.sv */
// Frame ring queue: a ring of FRAMES slots of up to FRAME_BYTES bytes each,
// with timestamp and two tags per frame. Depends on frq_pkg, frq_ctrl, frq_dp.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one transaction per push
//    byte, pop or drop. A transaction is taken when in_valid is high and
//    in_stall is low.
//  - Output channel (out_valid / out_stall) carries result transactions
//    from one output register; last marks the final one of an input item.
//  - Push: one byte per cycle unless stalled; bytes without end_of_frame give
//    no result, the end-of-frame byte one status result in the next cycle.
//  - Pop of n bytes: a first step reads the slot metadata and the first
//    byte from the registered memory read ports, then one byte leaves per
//    cycle unless the receiver stalls, paced by the payload memory read
//    port. Input stays stalled until the last byte is loaded. Pop with
//    read_limit zero yields one metadata-only result.
//  - Receiver stall holds the output register; while a result waits there
//    under stall the input is stalled as well, push bytes included.
//  - Reset empties the queue at once; memories are not cleared.
module frame_ring_queue import frq_pkg::*; #(
	parameter int FRAMES      = FRAMES_DEF,
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [OP_W-1:0]          opcode,
	input  logic [BYTE_W-1:0]        data_byte,
	input  logic                     end_of_frame,
	input  logic signed [TS_W-1:0]   timestamp,
	input  logic [TAG_W-1:0]         tag_a,
	input  logic [TAG_W-1:0]         tag_b,
	input  logic [LEN_W-1:0]         read_limit,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [STAT_W-1:0]        status,
	output logic                     byte_valid,
	output logic [BYTE_W-1:0]        out_byte,
	output logic                     last,
	output logic [LEN_W-1:0]         copied_length,
	output logic signed [TS_W-1:0]   out_timestamp,
	output logic [TAG_W-1:0]         out_tag_a,
	output logic [TAG_W-1:0]         out_tag_b
);

`include "frame_ring_queue_defines.svh"

	cmd_t  cmd;
	stat_t stat;

	frq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.opcode       (opcode),
		.end_of_frame (end_of_frame),
		.stat         (stat),
		.in_stall     (in_stall),
		.cmd          (cmd)
	);

	frq_dp #(
		.FRAMES      (FRAMES),
		.FRAME_BYTES (FRAME_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.data_byte     (data_byte),
		.end_of_frame  (end_of_frame),
		.timestamp     (timestamp),
		.tag_a         (tag_a),
		.tag_b         (tag_b),
		.read_limit    (read_limit),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.status        (status),
		.byte_valid    (byte_valid),
		.out_byte      (out_byte),
		.last          (last),
		.copied_length (copied_length),
		.out_timestamp (out_timestamp),
		.out_tag_a     (out_tag_a),
		.out_tag_b     (out_tag_b)
	);

	// checks on controller / datapath cooperation
	`FRQ_ASSERT_IMPL(a_load_room, clk, arst_n, cmd.out_load, stat.oready)
	`FRQ_ASSERT_NEXT(a_pop_holds_input, clk, arst_n, cmd.pop_start, in_stall)
	`FRQ_ASSERT_IMPL(a_no_adv_empty, clk, arst_n, cmd.pop_start || cmd.drop, !stat.empty)
	`FRQ_ASSERT_IMPL(a_pop_no_push, clk, arst_n, cmd.pop_next || cmd.pop_done, !cmd.push)

endmodule
